// ----- rtl/core/arm_joint_command_limiter_defines.svh -----
// Assertion macros shared by the arm joint command limiter RTL.
// Needs aclk and aresetn in scope at the point of use.
`ifndef ARM_JOINT_COMMAND_LIMITER_DEFINES_SVH
`define ARM_JOINT_COMMAND_LIMITER_DEFINES_SVH

// Checked only outside reset.
`define AJCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define AJCL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- rtl/core/ajcl_pkg.sv -----
// Package for the arm joint command limiter: constants, command keys,
// state struct and the pulse conversion. No dependencies.
package ajcl_pkg;

    localparam int NUM_JOINTS = 4;
    localparam int ANGLE_W    = 8;
    localparam int STEP_W     = 5;
    localparam int PULSE_W    = 8;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
    localparam logic [ANGLE_W-1:0] HOME_ONE    = 8'd90;
    localparam logic [ANGLE_W-1:0] HOME_TWO    = 8'd90;
    localparam logic [ANGLE_W-1:0] HOME_THREE  = 8'd45;
    localparam logic [ANGLE_W-1:0] HOME_FOUR   = 8'd100;
    localparam logic [ANGLE_W-1:0] J4_LOW_EXCL = 8'd80;
    localparam logic [ANGLE_W-1:0] J4_HIGH     = 8'd133;
    // Coupled rule of joints 2 and 3 reduces to 80 < p + other < 200.
    localparam logic [ANGLE_W:0]   COUPLE_MIN_EXCL = 9'd80;
    localparam logic [ANGLE_W:0]   COUPLE_MAX_EXCL = 9'd200;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 5'd3;

    localparam logic [PULSE_W-1:0] PULSE_BASE  = 8'd195;
    // floor(a/9) == (a*57) >> 9 for every a below 512
    localparam logic [5:0]         DIV9_MUL    = 6'd57;
    localparam int                 DIV9_SHIFT  = 9;

    // Command keys (ASCII)
    localparam logic [7:0] KEY_J1_UP   = 8'h6B; // k
    localparam logic [7:0] KEY_J1_DN   = 8'h3B; // ;
    localparam logic [7:0] KEY_J2_UP   = 8'h61; // a
    localparam logic [7:0] KEY_J2_DN   = 8'h71; // q
    localparam logic [7:0] KEY_J3_UP   = 8'h65; // e
    localparam logic [7:0] KEY_J3_DN   = 8'h64; // d
    localparam logic [7:0] KEY_J4_UP   = 8'h6F; // o
    localparam logic [7:0] KEY_J4_DN   = 8'h6C; // l
    localparam logic [7:0] KEY_HOME    = 8'h72; // r
    localparam logic [7:0] KEY_DIGIT_LO = 8'h31; // 1
    localparam logic [7:0] KEY_DIGIT_HI = 8'h39; // 9

    typedef struct packed {
        logic [NUM_JOINTS-1:0][ANGLE_W-1:0] angle;  // [0] is joint 1
        logic [STEP_W-1:0]                  step;
    } ajcl_state_t;

    localparam ajcl_state_t HOME_STATE = '{
        angle: {HOME_FOUR, HOME_THREE, HOME_TWO, HOME_ONE},
        step:  STEP_RESET
    };

    function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANGLE_W-1:0] a);
        logic [13:0] prod;
        logic [4:0]  quo;
        prod = {6'd0, a} * {8'd0, DIV9_MUL};
        quo  = prod[13:DIV9_SHIFT];
        return PULSE_BASE - {3'd0, quo};
    endfunction

endpackage

// ----- rtl/core/ajcl_update.sv -----
// Next-state logic of the joint command limiter: decodes one command
// packet against the current state. Depends on ajcl_pkg.
module ajcl_update (
    input  ajcl_pkg::ajcl_state_t cur,
    input  logic [7:0]            lead_byte,
    input  logic [7:0]            cmd,
    output ajcl_pkg::ajcl_state_t nxt
);
    import ajcl_pkg::*;

    function automatic logic couple_ok(input logic [ANGLE_W-1:0] p,
                                       input logic [ANGLE_W-1:0] other);
        logic [ANGLE_W:0] sum;
        sum = {1'b0, p} + {1'b0, other};
        return (sum > COUPLE_MIN_EXCL) && (sum < COUPLE_MAX_EXCL);
    endfunction

    function automatic logic joint_ok(input logic [1:0] j,
                                      input logic [ANGLE_W-1:0] p,
                                      input ajcl_state_t s);
        logic ok;
        case (j)
            2'd0:    ok = 1'b1;
            2'd1:    ok = couple_ok(p, s.angle[2]);
            2'd2:    ok = couple_ok(p, s.angle[1]);
            2'd3:    ok = (p > J4_LOW_EXCL) && (p <= J4_HIGH);
            default: ok = 1'b0;
        endcase
        return ok && (p <= ANGLE_MAX);
    endfunction

    logic [NUM_JOINTS-1:0]              up_go, dn_go;
    logic [NUM_JOINTS-1:0][ANGLE_W-1:0] up_p, dn_p;
    logic [ANGLE_W-1:0]                 home_two, home_three;
    logic [3:0]                         digit;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            logic [ANGLE_W:0] sum;
            sum      = {1'b0, cur.angle[j]} + {{(ANGLE_W+1-STEP_W){1'b0}}, cur.step};
            up_p[j]  = sum[ANGLE_W-1:0];
            dn_p[j]  = cur.angle[j] - {{(ANGLE_W-STEP_W){1'b0}}, cur.step};
            up_go[j] = (sum <= {1'b0, ANGLE_MAX}) && joint_ok(2'(j), up_p[j], cur);
            dn_go[j] = (cur.angle[j] >= {{(ANGLE_W-STEP_W){1'b0}}, cur.step})
                       && joint_ok(2'(j), dn_p[j], cur);
        end
    end

    // Home pose applies in order: joint 3 sees the new joint 2 angle.
    assign home_two   = couple_ok(HOME_TWO, cur.angle[2]) ? HOME_TWO : cur.angle[1];
    assign home_three = couple_ok(HOME_THREE, home_two) ? HOME_THREE : cur.angle[2];
    assign digit      = cmd[3:0];

    always_comb begin
        nxt = cur;
        if (lead_byte != 8'd0) begin
            case (cmd)
                KEY_J1_UP: if (up_go[0]) nxt.angle[0] = up_p[0];
                KEY_J1_DN: if (dn_go[0]) nxt.angle[0] = dn_p[0];
                KEY_J2_UP: if (up_go[1]) nxt.angle[1] = up_p[1];
                KEY_J2_DN: if (dn_go[1]) nxt.angle[1] = dn_p[1];
                KEY_J3_UP: if (up_go[2]) nxt.angle[2] = up_p[2];
                KEY_J3_DN: if (dn_go[2]) nxt.angle[2] = dn_p[2];
                KEY_J4_UP: if (up_go[3]) nxt.angle[3] = up_p[3];
                KEY_J4_DN: if (dn_go[3]) nxt.angle[3] = dn_p[3];
                KEY_HOME: begin
                    nxt.angle[0] = HOME_ONE;
                    nxt.angle[1] = home_two;
                    nxt.angle[2] = home_three;
                    if (joint_ok(2'd3, HOME_FOUR, cur)) nxt.angle[3] = HOME_FOUR;
                end
                default: begin
                    if (cmd >= KEY_DIGIT_LO && cmd <= KEY_DIGIT_HI) begin
                        nxt.step = {digit, 1'b0} + {1'b0, digit};
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/arm_joint_command_limiter.sv -----
// Top level of the arm joint command limiter: stream ports, joint state,
// output register with skid stage. Depends on ajcl_pkg, ajcl_update and
// arm_joint_command_limiter_defines.svh.
//
//  channel | dir | width | beat contents
//  --------+-----+-------+-------------------------------------------------
//  s_      | in  |  16   | lead_byte, cmd
//  m_      | out |  72   | angles 1..4, step_amount, pulses 1..4, zero pad
//
// One beat in per cycle while s_tready is high; each result is registered
//   in the output register (the skid register under a stall). The update is one
//   pass of compare/add logic from the joint state register into that register.
// Reset: aresetn low (sync) restores the home pose 90/90/45/100, step 3,
//   and empties the output and skid registers.
// Stalls: when m_tready is low the skid register takes one more beat;
//   s_tready drops only while the skid register holds a beat.
module arm_joint_command_limiter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] lead_byte, [15:8] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [7:0] angle_one, [15:8] angle_two,
                                   // [23:16] angle_three, [31:24] angle_four,
                                   // [36:32] step_amount, [44:37] pulse_one,
                                   // [52:45] pulse_two, [60:53] pulse_three,
                                   // [68:61] pulse_four, [71:69] zero
);
    import ajcl_pkg::*;
    `include "arm_joint_command_limiter_defines.svh"

    localparam int RES_W = NUM_JOINTS * ANGLE_W + STEP_W + NUM_JOINTS * PULSE_W;
    localparam int TDATA_W = 72;

    ajcl_state_t        state_reg, state_next;
    logic [RES_W-1:0]   result_word;
    logic [RES_W-1:0]   out_data_reg, skid_data_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               s_accept;
    logic [NUM_JOINTS-1:0][PULSE_W-1:0] pulses;

    ajcl_update u_update (
        .cur       (state_reg),
        .lead_byte (s_tdata[7:0]),
        .cmd       (s_tdata[15:8]),
        .nxt       (state_next)
    );

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            pulses[j] = pulse_of(state_next.angle[j]);
        end
    end

    // Result fields from the lowest bit up: angles, step, pulses.
    assign result_word = {pulses, state_next.step, state_next.angle};

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-RES_W){1'b0}}, out_data_reg};

    // Joint state moves only on an accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HOME_STATE;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register plus one skid entry; beats leave in arrival order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                out_data_reg <= result_word;
            end
        end else if (s_accept) begin
            skid_data_reg <= result_word;
        end
    end

    `AJCL_ASSERT(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid full with empty output")
    `AJCL_ASSERT(a_stall_fills_skid, (s_accept && out_valid_reg && !m_tready) |=> skid_valid_reg, "stalled beat not held in skid")
    `AJCL_ASSERT(a_angles_in_range, (state_reg.angle[0] <= ANGLE_MAX) && (state_reg.angle[1] <= ANGLE_MAX) && (state_reg.angle[2] <= ANGLE_MAX) && (state_reg.angle[3] > J4_LOW_EXCL) && (state_reg.angle[3] <= J4_HIGH), "joint angle outside its limits")
    `AJCL_ASSERT(a_state_holds_idle, !s_accept |=> $stable(state_reg), "joint state moved without a beat")
    `AJCL_ASSERT_RST(a_reset_home, !aresetn |=> (state_reg == HOME_STATE) && !out_valid_reg && !skid_valid_reg, "reset did not restore home pose")

endmodule

// ----- bench/ajcl_checker.sv -----
// Scoreboard for the arm joint command limiter: watches both stream channels,
// predicts each result beat and compares it field by field.
// Depends on ajcl_pkg for key codes, home pose and limits.
module ajcl_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] lead_byte, [15:8] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // angles 1..4, step_amount, pulses 1..4, pad
    output int unsigned mismatch_count,
    output int unsigned outstanding
);
    import ajcl_pkg::*;

    localparam int AMAX           = int'(ANGLE_MAX);
    localparam int COUPLE_SLACK   = 20;
    localparam int COUPLE_SPAN    = 100;
    localparam int STEP_PER_DIGIT = 3;
    localparam int PULSE_DIV      = 9;
    localparam int STEP_LSB       = 32;
    localparam int PULSE_LSB      = 37;
    localparam int PAD_LSB        = 69;

    logic [ANGLE_W-1:0] joint_pos [NUM_JOINTS];
    logic [STEP_W-1:0]  step_deg;
    logic [71:0]        expected_beats [$];
    int unsigned        errs;
    string              joint_tag [NUM_JOINTS] = '{"one", "two", "three", "four"};

    // Joint index 0..3; proposal p is dropped unless it passes that joint's rule.
    function automatic void try_angle(input int joint, input int p);
        int other;
        if (p < 0 || p > AMAX) return;
        case (joint)
            0: joint_pos[0] = 8'(p);
            1: begin
                other = int'(joint_pos[2]);
                if ((AMAX - other) > (p - COUPLE_SLACK) && (AMAX - other - p) < COUPLE_SPAN)
                    joint_pos[1] = 8'(p);
            end
            2: begin
                other = int'(joint_pos[1]);
                if ((AMAX - p) > (other - COUPLE_SLACK) && (AMAX - p - other) < COUPLE_SPAN)
                    joint_pos[2] = 8'(p);
            end
            default: begin
                if (p > int'(J4_LOW_EXCL) && p <= int'(J4_HIGH))
                    joint_pos[3] = 8'(p);
            end
        endcase
    endfunction

    function automatic void nudge(input int joint, input bit up);
        int cur;
        int s;
        cur = int'(joint_pos[joint[1:0]]);
        s   = int'(step_deg);
        if (up) begin
            if (cur <= AMAX - s) try_angle(joint, cur + s);
        end else if (cur >= s) begin
            try_angle(joint, cur - s);
        end
    endfunction

    // Updates the joint state for one packet and returns the expected result beat.
    function automatic logic [71:0] apply_packet(input logic [7:0] lead, input logic [7:0] key);
        logic [71:0] beat;
        if (lead != 8'd0) begin
            case (key)
                KEY_J1_UP: nudge(0, 1'b1);
                KEY_J1_DN: nudge(0, 1'b0);
                KEY_J2_UP: nudge(1, 1'b1);
                KEY_J2_DN: nudge(1, 1'b0);
                KEY_J3_UP: nudge(2, 1'b1);
                KEY_J3_DN: nudge(2, 1'b0);
                KEY_J4_UP: nudge(3, 1'b1);
                KEY_J4_DN: nudge(3, 1'b0);
                KEY_HOME: begin
                    // applied in order: joint 3 sees the new joint 2 angle
                    try_angle(0, int'(HOME_ONE));
                    try_angle(1, int'(HOME_TWO));
                    try_angle(2, int'(HOME_THREE));
                    try_angle(3, int'(HOME_FOUR));
                end
                default: begin
                    if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI)
                        step_deg = 5'(STEP_PER_DIGIT * (int'(key) - int'(KEY_DIGIT_LO) + 1));
                end
            endcase
        end
        beat = '0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            beat[j*8 +: 8]             = joint_pos[j];
            beat[PULSE_LSB + j*8 +: 8] = PULSE_BASE - 8'(joint_pos[j] / PULSE_DIV);
        end
        beat[STEP_LSB +: STEP_W] = step_deg;
        return beat;
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        logic [71:0] want;
        if (!aresetn) begin
            joint_pos[0] = HOME_ONE;
            joint_pos[1] = HOME_TWO;
            joint_pos[2] = HOME_THREE;
            joint_pos[3] = HOME_FOUR;
            step_deg     = STEP_RESET;
            expected_beats.delete();
            errs = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with no packet pending: %h", m_tdata);
                    errs++;
                end else begin
                    want = expected_beats.pop_front();
                    for (int j = 0; j < NUM_JOINTS; j++)
                        check_field({"angle_", joint_tag[j]}, want[j*8 +: 8], m_tdata[j*8 +: 8]);
                    check_field("step_amount", 8'(want[STEP_LSB +: STEP_W]),
                                8'(m_tdata[STEP_LSB +: STEP_W]));
                    for (int j = 0; j < NUM_JOINTS; j++)
                        check_field({"pulse_", joint_tag[j]}, want[PULSE_LSB + j*8 +: 8],
                                    m_tdata[PULSE_LSB + j*8 +: 8]);
                    check_field("tdata_pad", 8'(want[71:PAD_LSB]), 8'(m_tdata[71:PAD_LSB]));
                end
            end
            if (s_tvalid && s_tready)
                expected_beats.push_back(apply_packet(s_tdata[7:0], s_tdata[15:8]));
        end
        mismatch_count <= errs;
        outstanding    <= expected_beats.size();
    end

endmodule

// ----- bench/tb.sv -----
// Top of the arm joint command limiter bench: clock, reset, packet stimulus,
// idle/stall phases and verdict. Depends on ajcl_pkg, ajcl_checker and the DUT.
module tb;
    import ajcl_pkg::*;

    localparam int CYCLE_LIMIT      = 400000; // far above the slowest legal run
    localparam int HOLD_CYCLES      = 300;    // long m_tready hold-off
    localparam int HOLD_BURST       = 24;     // beats offered during the hold-off
    localparam int RANDOM_PER_PHASE = 200;
    localparam int DRAIN_CYCLES     = 10;     // DUT holds results in its output and skid registers

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        hold_req = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;

    logic [7:0] step_keys [8] = '{KEY_J1_UP, KEY_J1_DN, KEY_J2_UP, KEY_J2_DN,
                                  KEY_J3_UP, KEY_J3_DN, KEY_J4_UP, KEY_J4_DN};

    initial begin
        forever #5 aclk = ~aclk;
    end

    arm_joint_command_limiter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ajcl_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Receiver: random stalls, or a forced hold-off counted down here when
    // the stimulus asks for one. The hold-off lets the output and skid
    // registers fill so that s_tready drops.
    always @(posedge aclk) begin
        if (hold_req) hold_left = HOLD_CYCLES;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One packet beat. Idle cycles come first, so s_tvalid stays high
    // between back-to-back beats and is never dropped and raised in one step.
    task automatic send_packet(input logic [7:0] lead, input logic [7:0] key);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, lead};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly legal step/home/digit keys so the joints walk over their whole
    // range; some ignored packets (lead zero) and raw bytes as noise.
    task automatic send_random();
        logic [7:0]  lead;
        logic [7:0]  key;
        int unsigned roll;
        lead = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        roll = $urandom_range(0, 99);
        if (roll < 60)      key = step_keys[$urandom_range(0, 7)];
        else if (roll < 68) key = KEY_HOME;
        else if (roll < 83) key = 8'($urandom_range(KEY_DIGIT_LO, KEY_DIGIT_HI));
        else                key = 8'($urandom_range(0, 255));
        send_packet(lead, key);
    endtask

    // Stop offering beats until every predicted result has come back.
    // outstanding is a registered copy of the queue size, hence the first wait.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening, no idling
        send_packet(8'h00, KEY_J1_UP);          // ignored packet, state echoed
        send_packet(8'hFF, KEY_DIGIT_HI);       // step 27
        send_packet(8'h01, KEY_J1_UP);          // 117
        send_packet(8'h01, KEY_J1_UP);          // 144
        send_packet(8'h01, KEY_J1_UP);          // 171
        send_packet(8'h01, KEY_DIGIT_LO + 8'd2); // step 9
        send_packet(8'h01, KEY_J1_UP);          // 180, top of range
        send_packet(8'h01, KEY_J1_UP);          // would pass 180: no change
        send_packet(8'h01, KEY_DIGIT_LO - 8'd1); // '0' is not a step digit
        send_packet(8'h01, KEY_DIGIT_HI + 8'd1); // ':' neither
        send_packet(8'h01, KEY_J4_UP);          // 109
        send_packet(8'h01, KEY_J4_UP);          // 118
        send_packet(8'h01, KEY_J4_UP);          // 127
        send_packet(8'h01, KEY_J4_UP);          // 136 rejected, joint 4 max 133
        send_packet(8'h80, KEY_DIGIT_HI);       // step 27
        send_packet(8'h01, KEY_J4_DN);          // 100
        send_packet(8'h01, KEY_J4_DN);          // 73 rejected, joint 4 above 80
        send_packet(8'h01, KEY_J3_DN);          // 18
        send_packet(8'h01, KEY_J3_DN);          // step below zero: no change
        send_packet(8'h01, KEY_J2_DN);          // 63, sum 81 just passes coupling
        send_packet(8'h01, KEY_J2_DN);          // 36, coupled sum too low
        send_packet(8'h01, KEY_J3_UP);          // 45
        send_packet(8'h01, KEY_J2_UP);          // 90
        send_packet(8'h01, 8'h00);              // unknown keys
        send_packet(8'h01, 8'hFF);
        send_packet(8'h00, KEY_HOME);           // ignored home
        send_packet(8'h7F, KEY_HOME);
        wait_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 85; end
                default: begin send_idle_pct = 6; recv_stall_pct <= 6; end
            endcase
            if (phase == 0) begin
                // receiver holds off while beats keep coming: DUT fills and
                // backpressures the sender
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
                for (int i = 0; i < HOLD_BURST; i++) send_random();
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_random();
                if (i == RANDOM_PER_PHASE / 2) wait_drain();
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
